// ----- sv/sequencer_note_timing_macros.svh -----
// Assertion helpers for the note timing block
`ifndef SEQUENCER_NOTE_TIMING_MACROS_SVH
`define SEQUENCER_NOTE_TIMING_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SNT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define SNT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/snt_pkg.sv -----
`default_nettype none
package snt_pkg;

  localparam int unsigned DistW       = 9;   // |source - previous key| fits 9 bits
  localparam int unsigned FracBits    = 12;  // times 4096
  localparam int unsigned DvdW        = DistW + FracBits;
  localparam int unsigned DivRadix    = 3;   // quotient bits per cycle
  localparam int unsigned DivCycles   = DvdW / DivRadix;
  localparam int unsigned DivCntW     = $clog2(DivCycles);

  typedef enum logic [3:0] {
    OP_NOTE      = 4'd0,
    OP_REST      = 4'd1,
    OP_GATE      = 4'd2,
    OP_ATTR      = 4'd3,
    OP_TRIPLET   = 4'd4,
    OP_SLUR      = 4'd5,
    OP_DOTTED    = 4'd6,
    OP_OCT_UP    = 4'd7,
    OP_OCTAVE    = 4'd8,
    OP_PORTA     = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    KIND_NOTE   = 3'd0,
    KIND_REST   = 3'd1,
    KIND_TIME   = 3'd2,
    KIND_SRC    = 3'd3,
    KIND_LEGATO = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CFG_GLOBAL_TRANSPOSE = 1'b0,
    CFG_TRACK_TRANSPOSE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_GLIDE,
    ST_SRC,
    ST_MAIN
  } state_e;

  typedef enum logic [1:0] {
    SEL_TIME,
    SEL_SRC,
    SEL_MAIN
  } sel_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic emit;
    sel_e sel;
  } cmd_t;

  typedef struct packed {
    logic porta;     // valid during exec
    logic has_main;  // valid during exec
    logic time_new;  // valid after the divider finishes
  } status_t;

endpackage
`default_nettype wire

// ----- sv/sequencer_note_timing.sv -----
// A request is loaded, executed, then its result is registered; a portamento
// note first runs the divider (3 quotient bits per cycle, 21-bit dividend),
// then gives a glide time result (only if the glide time changed) and a source
// result before the main one, one per cycle while the output is not stalled.
// A request may give no result; a new one is taken only once the last is done.
// Reset: async active low; clears track state, transposes and output valid, no previous key.
`default_nettype none
module sequencer_note_timing (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  operation_i,
  input  wire logic [7:0]  note_key_i,
  input  wire logic [7:0]  raw_length_i,
  input  wire logic [7:0]  arg_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [6:0]       out_key_o,
  output logic             flag_o,
  output logic [7:0]       sounding_ticks_o,
  output logic [7:0]       advance_ticks_o,
  output logic [15:0]      glide_time_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);
  import snt_pkg::*;

  cmd_t    cmd;
  status_t status;

  snt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  snt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .note_key_i       (note_key_i),
    .raw_length_i     (raw_length_i),
    .arg_byte_i       (arg_byte_i),
    .event_kind_o     (event_kind_o),
    .out_key_o        (out_key_o),
    .flag_o           (flag_o),
    .sounding_ticks_o (sounding_ticks_o),
    .advance_ticks_o  (advance_ticks_o),
    .glide_time_o     (glide_time_o),
    .last_o           (last_o)
  );

`include "sequencer_note_timing_macros.svh"

  // one request in flight at a time
  `SNT_ASSERT_NEXT(a_one_request, in_valid_i && in_ready_o, !in_ready_o)
  // only portamento results precede the last result of a request
  `SNT_ASSERT_IMPL(a_nonlast_kind, out_valid_o && !last_o,
                   event_kind_o == KIND_TIME || event_kind_o == KIND_SRC)
  // a note always sounds
  `SNT_ASSERT_IMPL(a_note_sounds, out_valid_o && event_kind_o == KIND_NOTE,
                   sounding_ticks_o != 8'd0)

endmodule
`default_nettype wire

// ----- sv/snt_ctrl.sv -----
`default_nettype none
module snt_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire snt_pkg::status_t status_i,
  output snt_pkg::cmd_t        cmd_o
);
  import snt_pkg::*;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    cmd_o.sel  = SEL_MAIN;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        div_cnt_d  = '0;
        if (status_i.porta) begin
          state_d = ST_DIV;
        end else if (status_i.has_main) begin
          state_d = ST_MAIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(DivCycles - 1)) begin
          state_d = ST_GLIDE;
        end
      end
      ST_GLIDE: begin
        if (!status_i.time_new) begin
          state_d = ST_SRC;
        end else if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_TIME;
          state_d    = ST_SRC;
        end
      end
      ST_SRC: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_SRC;
          state_d    = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_MAIN;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- sv/snt_dp.sv -----
`default_nettype none
module snt_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire snt_pkg::cmd_t    cmd_i,
  output snt_pkg::status_t      status_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic [3:0]       operation_i,
  input  wire logic [7:0]       note_key_i,
  input  wire logic [7:0]       raw_length_i,
  input  wire logic [7:0]       arg_byte_i,
  output logic [2:0]            event_kind_o,
  output logic [6:0]            out_key_o,
  output logic                  flag_o,
  output logic [7:0]            sounding_ticks_o,
  output logic [7:0]            advance_ticks_o,
  output logic [15:0]           glide_time_o,
  output logic                  last_o
);
  import snt_pkg::*;

  // lengths per code: plain, after dotted, after triplet
  function automatic logic [7:0] timed_len(logic [7:0] code, logic dot, logic trip);
    logic [7:0] plain, dotl, tripl;
    plain = '0;
    dotl  = '0;
    tripl = '0;
    unique case (code[2:0])
      3'd1: begin plain = 8'd3;   dotl = 8'd0;   tripl = 8'd2;   end
      3'd2: begin plain = 8'd6;   dotl = 8'd9;   tripl = 8'd4;   end
      3'd3: begin plain = 8'd12;  dotl = 8'd18;  tripl = 8'd8;   end
      3'd4: begin plain = 8'd24;  dotl = 8'd36;  tripl = 8'd16;  end
      3'd5: begin plain = 8'd48;  dotl = 8'd72;  tripl = 8'd32;  end
      3'd6: begin plain = 8'd96;  dotl = 8'd144; tripl = 8'd64;  end
      3'd7: begin plain = 8'd192; dotl = 8'd0;   tripl = 8'd128; end
      default: begin plain = 8'd0; dotl = 8'd0;  tripl = 8'd0;   end
    endcase
    if (code[7:3] != 5'd0) begin
      plain = '0;
      dotl  = '0;
      tripl = '0;
    end
    if (dot) begin
      return dotl;
    end else if (trip) begin
      return tripl;
    end
    return plain;
  endfunction

  function automatic logic [6:0] clamp_key(logic signed [10:0] k);
    if (k[10]) begin
      return 7'd0;
    end else if (k[9:7] != 3'd0) begin
      return 7'd127;
    end
    return k[6:0];
  endfunction

  // input request
  logic [3:0] op_q;
  logic [7:0] key_q, len_code_q, arg_q;

  // track state
  logic              dotted_q, dotted_d;
  logic              triplet_q, triplet_d;
  logic              slurred_q, slurred_d;
  logic              oct_up_q, oct_up_d;
  logic [2:0]        octave_q, octave_d;
  logic [7:0]        gate_rate_q, gate_rate_d;
  logic signed [9:0] prev_key_q, prev_key_d;
  logic              prev_slur_q, prev_slur_d;
  logic              rested_q, rested_d;
  logic [7:0]        glide_step_q, glide_step_d;
  logic [15:0]       prev_glide_q;
  logic [7:0]        gt_q, tt_q;

  // results computed during exec
  logic [2:0] main_kind_q, main_kind;
  logic [6:0] main_key_q, main_key;
  logic       main_flag_q, main_flag;
  logic [7:0] main_snd_q, main_snd;
  logic [7:0] main_adv_q, main_adv;
  logic [6:0] src_key_q;

  // divider
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [7:0]      rem_q, rem_d;
  logic [15:0]     glide_sat;

  // note arithmetic
  logic [7:0]         len;
  logic [15:0]        prod, gate, gate_rnd;
  logic [7:0]         snd_base;
  logic signed [9:0]  src;
  logic signed [10:0] key_sum, pk_sum, diff, adiff;
  logic               ext, porta;
  logic [DistW-1:0]   span;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= operation_i;
      key_q      <= note_key_i;
      len_code_q <= raw_length_i;
      arg_q      <= arg_byte_i;
    end
    if (cmd_i.exec) begin
      main_kind_q <= main_kind;
      main_key_q  <= main_key;
      main_flag_q <= main_flag;
      main_snd_q  <= main_snd;
      main_adv_q  <= main_adv;
      src_key_q   <= clamp_key(pk_sum);
    end
    if (cmd_i.exec || cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dotted_q     <= 1'b0;
      triplet_q    <= 1'b0;
      slurred_q    <= 1'b0;
      oct_up_q     <= 1'b0;
      octave_q     <= '0;
      gate_rate_q  <= '0;
      prev_key_q   <= '1;
      prev_slur_q  <= 1'b0;
      rested_q     <= 1'b0;
      glide_step_q <= '0;
      prev_glide_q <= '0;
      gt_q         <= '0;
      tt_q         <= '0;
    end else begin
      if (cmd_i.exec) begin
        dotted_q     <= dotted_d;
        triplet_q    <= triplet_d;
        slurred_q    <= slurred_d;
        oct_up_q     <= oct_up_d;
        octave_q     <= octave_d;
        gate_rate_q  <= gate_rate_d;
        prev_key_q   <= prev_key_d;
        prev_slur_q  <= prev_slur_d;
        rested_q     <= rested_d;
        glide_step_q <= glide_step_d;
      end
      if (cmd_i.emit && cmd_i.sel == SEL_TIME) begin
        prev_glide_q <= glide_sat;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GLOBAL_TRANSPOSE: gt_q <= cfg_data_i;
          CFG_TRACK_TRANSPOSE:  tt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // note arithmetic from the registered request
  always_comb begin
    len      = timed_len(len_code_q, dotted_q, triplet_q);
    prod     = 16'(len) * 16'(gate_rate_q);
    gate     = (slurred_q || prod == 16'd0) ? {len, 8'h00} : prod;
    gate_rnd = gate + 16'd128;
    snd_base = (gate_rnd[15:8] == 8'd0) ? 8'd1 : gate_rnd[15:8];
    src      = signed'(10'(key_q) - 10'd1 + 10'(octave_q) * 10'd12
                       + (oct_up_q ? 10'd24 : 10'd0));
    key_sum  = {src[9], src} + {{3{gt_q[7]}}, gt_q} + {{3{tt_q[7]}}, tt_q};
    pk_sum   = {prev_key_q[9], prev_key_q} + {{3{gt_q[7]}}, gt_q};
    ext      = prev_slur_q && (src == prev_key_q) && !rested_q;
    porta    = !ext && (glide_step_q != 8'd0) && !prev_key_q[9];
    diff     = {src[9], src} - {prev_key_q[9], prev_key_q};
    adiff    = diff[10] ? -diff : diff;
    span     = adiff[DistW-1:0];
  end

  // state update and main result
  always_comb begin
    dotted_d     = dotted_q;
    triplet_d    = triplet_q;
    slurred_d    = slurred_q;
    oct_up_d     = oct_up_q;
    octave_d     = octave_q;
    gate_rate_d  = gate_rate_q;
    prev_key_d   = prev_key_q;
    prev_slur_d  = prev_slur_q;
    rested_d     = rested_q;
    glide_step_d = glide_step_q;
    main_kind    = KIND_LEGATO;
    main_key     = '0;
    main_flag    = 1'b0;
    main_snd     = '0;
    main_adv     = '0;
    status_o.has_main = 1'b0;
    status_o.porta    = 1'b0;
    status_o.time_new = (glide_sat != prev_glide_q);
    unique case (op_q)
      OP_NOTE: begin
        dotted_d    = 1'b0;
        prev_slur_d = slurred_q;
        if (!ext) begin
          prev_key_d = src;
          rested_d   = 1'b0;
        end
        main_kind         = KIND_NOTE;
        main_key          = clamp_key(key_sum);
        main_flag         = ext;
        main_snd          = snd_base + 8'((!ext && slurred_q) ? 1 : 0);
        main_adv          = len;
        status_o.has_main = 1'b1;
        status_o.porta    = porta;
      end
      OP_REST: begin
        dotted_d          = 1'b0;
        rested_d          = 1'b1;
        main_kind         = KIND_REST;
        main_adv          = len;
        status_o.has_main = 1'b1;
      end
      OP_GATE: gate_rate_d = arg_q;
      OP_ATTR: begin
        octave_d          = octave_q | arg_q[2:0];
        dotted_d          = dotted_q | arg_q[4];
        oct_up_d          = arg_q[3];
        triplet_d         = arg_q[5];
        slurred_d         = arg_q[6];
        main_flag         = arg_q[6];
        status_o.has_main = (arg_q[6] != slurred_q);
      end
      OP_TRIPLET: triplet_d = !triplet_q;
      OP_SLUR: begin
        slurred_d         = !slurred_q;
        main_flag         = !slurred_q;
        status_o.has_main = 1'b1;
      end
      OP_DOTTED:  dotted_d     = 1'b1;
      OP_OCT_UP:  oct_up_d     = !oct_up_q;
      OP_OCTAVE:  octave_d     = arg_q[2:0];
      OP_PORTA:   glide_step_d = {arg_q[6:0], 1'b0};
      default: ;
    endcase
  end

  // restoring divider, DivRadix quotient bits per step; quotient shifts into dvd
  always_comb begin
    logic [8:0] trial;
    trial = '0;
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.exec) begin
      dvd_d = {span, FracBits'(0)};
      rem_d = '0;
    end else begin
      for (int i = 0; i < DivRadix; i++) begin
        trial = {rem_d, dvd_d[DvdW-1]};
        dvd_d = {dvd_d[DvdW-2:0], 1'b0};
        if (trial >= {1'b0, glide_step_q}) begin
          rem_d    = 8'(trial - {1'b0, glide_step_q});
          dvd_d[0] = 1'b1;
        end else begin
          rem_d = trial[7:0];
        end
      end
    end
  end

  assign glide_sat = (dvd_q[DvdW-1:16] != '0) ? 16'hFFFF : dvd_q[15:0];

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.sel)
        SEL_TIME: begin
          event_kind_o     <= KIND_TIME;
          out_key_o        <= '0;
          flag_o           <= 1'b0;
          sounding_ticks_o <= '0;
          advance_ticks_o  <= '0;
          glide_time_o     <= glide_sat;
          last_o           <= 1'b0;
        end
        SEL_SRC: begin
          event_kind_o     <= KIND_SRC;
          out_key_o        <= src_key_q;
          flag_o           <= 1'b0;
          sounding_ticks_o <= '0;
          advance_ticks_o  <= '0;
          glide_time_o     <= '0;
          last_o           <= 1'b0;
        end
        default: begin
          event_kind_o     <= main_kind_q;
          out_key_o        <= main_key_q;
          flag_o           <= main_flag_q;
          sounding_ticks_o <= main_snd_q;
          advance_ticks_o  <= main_adv_q;
          glide_time_o     <= '0;
          last_o           <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
